[design/assert_macros.svh]
// assertion helpers used by the grid ray wall caster design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define GWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gwc check failed");

// next-cycle implication
`define GWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gwc check failed");

`endif

[design/gwc_pkg.sv]
// ----------------------------------------------------------------------------
// gwc_pkg
// Shared constants and widths for the grid ray wall caster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwc_pkg;

  // default geometry
  localparam int GRID_CELLS_DEF    = 8;
  localparam int CELL_UNITS_DEF    = 40;
  localparam int FRACTION_BITS_DEF = 7;
  localparam int ANGLE_BITS_DEF    = 12;

  // datapath widths, sized for the widest legal geometry
  localparam int COORD_W   = 40;  // ray coordinates while marching
  localparam int DIFF_W    = 22;  // in-grid coordinate or offset magnitude
  localparam int SCD_W     = 19;  // scale operand, at most one cell
  localparam int SIN_W     = 18;  // signed q16 sine
  localparam int MUL_W     = 23;  // shared multiplier operand
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIVN_W    = 36;  // dividend of the scale divider
  localparam int DIVD_W    = 17;  // divisor magnitude
  localparam int SQ_W      = 46;  // squared length, even
  localparam int LEN_W     = SQ_W / 2;
  localparam int ANG_MAX_W = 14;
  localparam int IDX_W     = 6;   // wall map bit index
  localparam int CELL_W    = 3;   // cell coordinate

  // sine polynomial coefficients, q16
  localparam logic [16:0] SIN_C1  = 17'd102944;
  localparam logic [16:0] SIN_C3  = 17'd42177;
  localparam logic [16:0] SIN_C5  = 17'd4769;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [15:0] FAR_DIST = 16'hFFFF;

endpackage

`default_nettype wire

[design/grid_ray_wall_caster.sv]
// ----------------------------------------------------------------------------
// grid_ray_wall_caster
// Casts one ray over an 8x8 wall grid and returns the nearer wall hit.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_write/cfg_data load the 64-bit wall map (bit row*8+col is a wall);
//   write it only while busy is low.
//   A ray word is taken at a rising edge with start high and busy low:
//   pos_x, pos_y, ray_angle and view_angle.
//   busy stays high while the ray is worked on; no new word is taken then.
//   The result word (hit_found, hit_x, hit_y, wall_distance, hit_side) is
//   shown for one cycle with done high, the first cycle with busy low.
//   The receiver cannot stall; done is a single-cycle strobe.
// Schedule: one ray is worked on at a time; a new ray word is not taken
//   until the result word is out. The one shared multiplier is used by a
//   small sequencer: two sine evaluations and a third when a wall is hit,
//   up to four scale divisions in a one-bit-per-cycle divider, up to eight
//   wall tests per pass, and a square root when a wall is hit.
//   The next ray may start the cycle done is high.
// Reset: rst clears the wall map and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module grid_ray_wall_caster import gwc_pkg::*; #(
  parameter int GRID_CELLS    = GRID_CELLS_DEF,
  parameter int CELL_UNITS    = CELL_UNITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [11:0] ray_angle,
  input  wire logic [11:0] view_angle,
  input  wire logic        cfg_write,
  input  wire logic [63:0] cfg_data,
  output logic             done,
  output logic             hit_found,
  output logic [15:0]      hit_x,
  output logic [15:0]      hit_y,
  output logic [15:0]      wall_distance,
  output logic             hit_side
);

  localparam int CELL_FX = CELL_UNITS << FRACTION_BITS;
  localparam int GRID_FX = GRID_CELLS * CELL_FX;
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int USHIFT  = 18 - ANGLE_BITS;
  localparam logic signed [COORD_W-1:0] CELL_S = COORD_W'(CELL_FX);

  // reciprocal of the cell size, exact floor quotient for 16-bit positions
  localparam int     RECIP_K = 16 + $clog2(CELL_FX);
  localparam longint RECIP_M = ((longint'(1) << RECIP_K) + CELL_FX - 1) / CELL_FX;

  // which sine is being evaluated
  localparam logic [1:0] TRIG_RAY_SIN  = 2'd0;
  localparam logic [1:0] TRIG_RAY_COS  = 2'd1;
  localparam logic [1:0] TRIG_VIEW_COS = 2'd2;

  // which scale product is being formed
  localparam logic [1:0] PH_V_FIRST = 2'd0;
  localparam logic [1:0] PH_V_STEP  = 2'd1;
  localparam logic [1:0] PH_H_FIRST = 2'd2;
  localparam logic [1:0] PH_H_STEP  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SIN_SETUP, S_SIN_U2, S_SIN_IN, S_SIN_OUT, S_SIN_P,
    S_V_INIT, S_H_INIT, S_SC_MUL, S_SC_DIV, S_MARCH, S_DIST_X, S_DIST_Y,
    S_SEL, S_SQRT, S_FIN
  } state_t;

  state_t state;

  logic [63:0]             wall_map;
  logic [15:0]             px_r, py_r;
  logic [ANGLE_BITS-1:0]   ray_a, view_a, ang;
  logic [1:0]              trig_idx, phase, quad_r;
  logic [16:0]             u, u2, inner, outer;
  logic signed [SIN_W-1:0] s_val, c_val, cf_val;
  logic [SCD_W-1:0]        sc_d;
  logic signed [COORD_W-1:0] x_cur, y_cur, step_x, step_y;
  logic [2:0]              cnt;
  logic [PROD_W-1:0]       acc;
  logic                    vhit, hhit;
  logic [SQ_W-1:0]         dv2, dh2;
  logic [15:0]             vhx, vhy, hhx, hhy;
  logic [LEN_W-1:0]        len;

  // ---------------------------------------------------------------- angles
  logic [ANG_MAX_W-1:0] ray_ext, view_ext;
  assign ray_ext  = ANG_MAX_W'(ray_angle);
  assign view_ext = ANG_MAX_W'(view_angle);

  // sine argument folded onto the first quadrant
  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] r_raw, r_fold;
  logic [16:0]           u_init;
  assign quad   = ang[ANGLE_BITS-1 -: 2];
  assign r_raw  = {1'b0, ang[ANGLE_BITS-3:0]};
  assign r_fold = quad[0] ? (ANGLE_BITS-1)'(QUARTER) - r_raw : r_raw;
  assign u_init = 17'(r_fold) << USHIFT;

  // ------------------------------------------------------- scale operands
  logic signed [SIN_W-1:0] num, den;
  logic [DIVD_W-1:0]       num_abs, den_abs;
  assign num     = phase[1] ? c_val : s_val;
  assign den     = phase[1] ? s_val : c_val;
  assign num_abs = DIVD_W'(num[SIN_W-1] ? -num : num);
  assign den_abs = DIVD_W'(den[SIN_W-1] ? -den : den);

  // ------------------------------------------------------ offsets to hit
  logic signed [COORD_W-1:0] px_s, py_s, dx, dy;
  logic [DIFF_W-1:0]         adx, ady;
  assign px_s = COORD_W'(px_r);
  assign py_s = COORD_W'(py_r);
  assign dx   = x_cur - px_s;
  assign dy   = y_cur - py_s;
  assign adx  = DIFF_W'(dx[COORD_W-1] ? -dx : dx);
  assign ady  = DIFF_W'(dy[COORD_W-1] ? -dy : dy);

  // ------------------------------------------------------ shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SIN_U2:  begin mul_a = MUL_W'(u);      mul_b = MUL_W'(u);       end
      S_SIN_IN:  begin mul_a = MUL_W'(u2);     mul_b = MUL_W'(SIN_C5);  end
      S_SIN_OUT: begin mul_a = MUL_W'(u2);     mul_b = MUL_W'(inner);   end
      S_SIN_P:   begin mul_a = MUL_W'(u);      mul_b = MUL_W'(outer);   end
      S_SC_MUL:  begin mul_a = MUL_W'(sc_d);   mul_b = MUL_W'(num_abs); end
      S_DIST_X:  begin mul_a = MUL_W'(adx);    mul_b = MUL_W'(adx);     end
      S_DIST_Y:  begin mul_a = MUL_W'(ady);    mul_b = MUL_W'(ady);     end
      S_FIN:     begin mul_a = MUL_W'(len);    mul_b = MUL_W'(cf_val[16:0]); end
      default:   begin mul_a = '0;             mul_b = '0;              end
    endcase
  end

  assign prod = mul_a * mul_b;

  // clamped, signed sine from the last polynomial product
  logic [16:0]             p_raw, p_cl;
  logic signed [SIN_W-1:0] sin_res;
  assign p_raw   = prod[32:16];
  assign p_cl    = (p_raw > ONE_Q16) ? ONE_Q16 : p_raw;
  assign sin_res = quad_r[1] ? -SIN_W'(p_cl) : SIN_W'(p_cl);

  // -------------------------------------------------------------- divider
  logic               div_done;
  logic [DIVN_W-1:0]  quo;
  logic signed [COORD_W-1:0] q_signed;

  gwc_div #(.NUM_W(DIVN_W), .DEN_W(DIVD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SC_MUL),
    .dividend (prod[DIVN_W-1:0]),
    .divisor  (den_abs),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_signed = num[SIN_W-1] ? -COORD_W'(quo) : COORD_W'(quo);

  // ------------------------------------------------------------ wall test
  logic             in_grid, wall;
  logic [CELL_W-1:0] cx, cy;
  logic [IDX_W-1:0] idx;
  assign in_grid = !x_cur[COORD_W-1] && !y_cur[COORD_W-1] &&
                   (x_cur[COORD_W-2:0] < (COORD_W-1)'(GRID_FX)) &&
                   (y_cur[COORD_W-2:0] < (COORD_W-1)'(GRID_FX));

  // cell coordinates by compares against the cell boundaries
  always_comb begin
    cx = '0;
    cy = '0;
    for (int k = 1; k < GRID_CELLS; k++) begin
      if (x_cur[DIFF_W-1:0] >= DIFF_W'(k * CELL_FX)) cx = CELL_W'(k);
      if (y_cur[DIFF_W-1:0] >= DIFF_W'(k * CELL_FX)) cy = CELL_W'(k);
    end
  end

  assign idx  = IDX_W'(IDX_W'(cy) * IDX_W'(GRID_CELLS) + IDX_W'(cx));
  assign wall = in_grid && wall_map[idx];

  // ------------------------------------------------------- pass start points
  logic [15:0]               pcx, pcy;
  logic [33:0]               pcx_prod, pcy_prod;
  logic signed [COORD_W-1:0] base_x, base_y, vx0, hy0, vd, hd;
  assign pcx_prod = 34'(pos_x) * 34'(RECIP_M);
  assign pcy_prod = 34'(pos_y) * 34'(RECIP_M);
  assign base_x = COORD_W'(pcx) * COORD_W'(CELL_FX);
  assign base_y = COORD_W'(pcy) * COORD_W'(CELL_FX);
  assign vx0    = (c_val > 0) ? base_x + CELL_S : base_x - 1;
  assign vd     = (c_val > 0) ? vx0 - px_s : px_s - vx0;
  assign hy0    = (s_val < 0) ? base_y + CELL_S : base_y - 1;
  assign hd     = (s_val < 0) ? hy0 - py_s : py_s - hy0;

  // ------------------------------------------------------- hit selection
  logic            pick_h, found;
  logic [SQ_W-1:0] sq_in;
  assign pick_h = hhit && (!vhit || dh2 < dv2);
  assign found  = hhit || vhit;
  assign sq_in  = pick_h ? dh2 : dv2;

  logic             sq_done;
  logic [LEN_W-1:0] sq_root;

  gwc_isqrt #(.IN_W(SQ_W)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SEL && found),
    .value (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  // final scaled distance
  logic [PROD_W-17:0] dist_full;
  logic               cf_pos;
  assign dist_full = prod[PROD_W-1:16];
  assign cf_pos    = !cf_val[SIN_W-1] && (cf_val != '0);

  assign busy = (state != S_IDLE);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wall_map <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        wall_map <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            px_r     <= pos_x;
            py_r     <= pos_y;
            pcx      <= 16'(pcx_prod >> RECIP_K);
            pcy      <= 16'(pcy_prod >> RECIP_K);
            ray_a    <= ray_ext[ANGLE_BITS-1:0];
            view_a   <= view_ext[ANGLE_BITS-1:0];
            ang      <= ray_ext[ANGLE_BITS-1:0];
            trig_idx <= TRIG_RAY_SIN;
            state    <= S_SIN_SETUP;
          end
        end
        S_SIN_SETUP: begin
          u      <= u_init;
          quad_r <= quad;
          state  <= S_SIN_U2;
        end
        S_SIN_U2: begin
          u2    <= prod[32:16];
          state <= S_SIN_IN;
        end
        S_SIN_IN: begin
          inner <= SIN_C3 - prod[32:16];
          state <= S_SIN_OUT;
        end
        S_SIN_OUT: begin
          outer <= SIN_C1 - prod[32:16];
          state <= S_SIN_P;
        end
        S_SIN_P: begin
          case (trig_idx)
            TRIG_RAY_SIN: begin
              s_val    <= sin_res;
              ang      <= ray_a + ANGLE_BITS'(QUARTER);
              trig_idx <= TRIG_RAY_COS;
              state    <= S_SIN_SETUP;
            end
            TRIG_RAY_COS: begin
              c_val <= sin_res;
              state <= S_V_INIT;
            end
            default: begin
              cf_val <= sin_res;
              state  <= S_FIN;
            end
          endcase
        end
        S_V_INIT: begin
          vhit <= 1'b0;
          if (c_val == '0) begin
            state <= S_H_INIT;
          end else begin
            x_cur <= vx0;
            sc_d  <= SCD_W'(vd);
            phase <= PH_V_FIRST;
            state <= S_SC_MUL;
          end
        end
        S_H_INIT: begin
          hhit <= 1'b0;
          if (s_val == '0) begin
            state <= S_SEL;
          end else begin
            y_cur <= hy0;
            sc_d  <= SCD_W'(hd);
            phase <= PH_H_FIRST;
            state <= S_SC_MUL;
          end
        end
        S_SC_MUL: begin
          state <= S_SC_DIV;
        end
        S_SC_DIV: begin
          if (div_done) begin
            cnt <= '0;
            case (phase)
              PH_V_FIRST: begin
                y_cur <= py_s - q_signed;
                sc_d  <= SCD_W'(CELL_FX);
                phase <= PH_V_STEP;
                state <= S_SC_MUL;
              end
              PH_V_STEP: begin
                step_y <= -q_signed;
                step_x <= (c_val > 0) ? CELL_S : -CELL_S;
                state  <= S_MARCH;
              end
              PH_H_FIRST: begin
                x_cur <= px_s + q_signed;
                sc_d  <= SCD_W'(CELL_FX);
                phase <= PH_H_STEP;
                state <= S_SC_MUL;
              end
              PH_H_STEP: begin
                step_x <= q_signed;
                step_y <= (s_val < 0) ? CELL_S : -CELL_S;
                state  <= S_MARCH;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MARCH: begin
          if (wall) begin
            state <= S_DIST_X;
          end else if (cnt == 3'(GRID_CELLS - 1)) begin
            state <= phase[1] ? S_SEL : S_H_INIT;
          end else begin
            x_cur <= x_cur + step_x;
            y_cur <= y_cur + step_y;
            cnt   <= cnt + 1'b1;
          end
        end
        S_DIST_X: begin
          acc   <= prod;
          state <= S_DIST_Y;
        end
        S_DIST_Y: begin
          if (phase[1]) begin
            hhit  <= 1'b1;
            dh2   <= SQ_W'(acc + prod);
            hhx   <= x_cur[15:0];
            hhy   <= y_cur[15:0];
            state <= S_SEL;
          end else begin
            vhit  <= 1'b1;
            dv2   <= SQ_W'(acc + prod);
            vhx   <= x_cur[15:0];
            vhy   <= y_cur[15:0];
            state <= S_H_INIT;
          end
        end
        S_SEL: begin
          hit_found <= found;
          hit_side  <= pick_h;
          hit_x     <= pick_h ? hhx : (vhit ? vhx : 16'd0);
          hit_y     <= pick_h ? hhy : (vhit ? vhy : 16'd0);
          if (found) begin
            state <= S_SQRT;
          end else begin
            wall_distance <= FAR_DIST;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            len      <= sq_root;
            ang      <= view_a - ray_a + ANGLE_BITS'(QUARTER);
            trig_idx <= TRIG_VIEW_COS;
            state    <= S_SIN_SETUP;
          end
        end
        S_FIN: begin
          if (!cf_pos) begin
            wall_distance <= 16'd0;
          end else if (|dist_full[PROD_W-17:16]) begin
            wall_distance <= FAR_DIST;
          end else begin
            wall_distance <= dist_full[15:0];
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------------ assertions
  `GWC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GWC_ASSERT_NOW(a_done_idle, done, !busy)
  `GWC_ASSERT_NEXT(a_done_single, done, !done)
  `GWC_ASSERT_NOW(a_miss_far, done && !hit_found, wall_distance == FAR_DIST && !hit_side)

endmodule

`default_nettype wire

[design/gwc_div.sv]
// ----------------------------------------------------------------------------
// gwc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwc_div import gwc_pkg::*; #(
  parameter int NUM_W = DIVN_W,
  parameter int DEN_W = DIVD_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic             fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        rem      <= fits ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
        quotient <= {quotient[NUM_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/gwc_isqrt.sv]
// ----------------------------------------------------------------------------
// gwc_isqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwc_isqrt import gwc_pkg::*; #(
  parameter int IN_W = SQ_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [IN_W-1:0]   value,
  output logic                   done,
  output logic [IN_W/2-1:0]      root
);

  localparam int H     = IN_W / 2;
  localparam int CNT_W = $clog2(H);

  logic [IN_W-1:0]  val;
  logic [H+1:0]     rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [H+3:0]     trial_rem;
  logic [H+3:0]     trial;
  logic             fits;

  // bring down two bits and test the next root bit
  assign trial_rem = {rem, val[IN_W-1 -: 2]};
  assign trial     = (H+4)'({root, 2'b01});
  assign fits      = trial_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        val  <= value;
      end else if (run) begin
        rem  <= fits ? (H+2)'(trial_rem - trial) : (H+2)'(trial_rem);
        root <= {root[H-2:0], fits};
        val  <= {val[IN_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(H - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/gwc_checker.sv]
// ----------------------------------------------------------------------------
// gwc_checker
// Watches the ray and result words of the grid ray wall caster. It predicts
// each result from its own copy of the wall map and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwc_checker import gwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [11:0] ray_angle,
  input  logic [11:0] view_angle,
  input  logic        cfg_write,
  input  logic [63:0] cfg_data,
  input  logic        done,
  input  logic        hit_found,
  input  logic [15:0] hit_x,
  input  logic [15:0] hit_y,
  input  logic [15:0] wall_distance,
  input  logic        hit_side,
  output int          fail_count,
  output int          pending,
  output int          hit_count
);

  localparam longint CELL_FX  = longint'(CELL_UNITS_DEF) << FRACTION_BITS_DEF;
  localparam int     GRID     = GRID_CELLS_DEF;
  localparam int     ANG_N    = 1 << ANGLE_BITS_DEF;
  localparam int     ANG_Q    = ANG_N >> 2;
  localparam bit     SIDE_VERT  = 1'b0;
  localparam bit     SIDE_HORIZ = 1'b1;

  typedef struct packed {
    logic        found;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] distance;
    logic        side;
  } wall_hit_t;

  logic [63:0] walls;
  wall_hit_t   hits_due[$];

  // polynomial sine, q16, on a quarter turn mirrored per quadrant
  function automatic longint sine_q16(input int unsigned a);
    int unsigned quad, r;
    longint unsigned u, u2, inner, outer, p;
    a = a & (ANG_N - 1);
    quad = a >> (ANGLE_BITS_DEF - 2);
    r = a & (ANG_Q - 1);
    if (quad & 1) r = ANG_Q - r;
    u = (longint'(r) << 16) >> (ANGLE_BITS_DEF - 2);
    u2 = (u * u) >> 16;
    inner = SIN_C3 - ((u2 * SIN_C5) >> 16);
    outer = SIN_C1 - ((u2 * inner) >> 16);
    p = (u * outer) >> 16;
    if (p > ONE_Q16) p = ONE_Q16;
    return (quad & 2) ? -longint'(p) : longint'(p);
  endfunction

  // truncated d*num/den carrying the sign of num
  function automatic longint tan_step(input longint d, input longint num, input longint den);
    longint q;
    q = (d * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
    return num < 0 ? -q : q;
  endfunction

  function automatic bit cell_is_wall(input longint x, input longint y);
    longint cx, cy;
    if (x < 0 || y < 0) return 1'b0;
    cx = x / CELL_FX;
    cy = y / CELL_FX;
    if (cx >= GRID || cy >= GRID) return 1'b0;
    return walls[cy * GRID + cx];
  endfunction

  function automatic bit walk_ray(inout longint x, inout longint y,
                                  input longint sx, input longint sy);
    for (int i = 0; i < GRID; i++) begin
      if (cell_is_wall(x, y)) return 1'b1;
      x += sx;
      y += sy;
    end
    return 1'b0;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // nearer wall hit of one ray
  function automatic wall_hit_t cast_ray(input logic [15:0] px16, input logic [15:0] py16,
                                         input logic [11:0] ray_in, input logic [11:0] view_in);
    longint px, py, s, c, vx, vy, hx, hy, d, fx, fy, cf;
    longint unsigned dv2, dh2, d2, len, dist_q;
    bit vhit, hhit, found, side;
    int unsigned ray, view;
    wall_hit_t res;
    px = px16; py = py16;
    ray = ray_in; view = view_in;
    s = sine_q16(ray);
    c = sine_q16(ray + ANG_Q);
    vx = 0; vy = 0; hx = 0; hy = 0;
    vhit = 0; hhit = 0; found = 1; dv2 = 0; dh2 = 0;
    // vertical grid lines
    if (c != 0) begin
      if (c > 0) begin
        vx = (px / CELL_FX) * CELL_FX + CELL_FX;
        d = vx - px;
      end else begin
        vx = (px / CELL_FX) * CELL_FX - 1;
        d = px - vx;
      end
      vy = py - tan_step(d, s, c);
      vhit = walk_ray(vx, vy, c > 0 ? CELL_FX : -CELL_FX, -tan_step(CELL_FX, s, c));
      if (vhit) dv2 = (vx - px) * (vx - px) + (vy - py) * (vy - py);
    end
    // horizontal grid lines
    if (s != 0) begin
      if (s < 0) begin
        hy = (py / CELL_FX) * CELL_FX + CELL_FX;
        d = hy - py;
      end else begin
        hy = (py / CELL_FX) * CELL_FX - 1;
        d = py - hy;
      end
      hx = px + tan_step(d, c, s);
      hhit = walk_ray(hx, hy, tan_step(CELL_FX, c, s), s < 0 ? CELL_FX : -CELL_FX);
      if (hhit) dh2 = (hx - px) * (hx - px) + (hy - py) * (hy - py);
    end
    // horizontal wins only when strictly nearer
    if (hhit && (!vhit || dh2 < dv2)) begin
      fx = hx; fy = hy; d2 = dh2; side = SIDE_HORIZ;
    end else if (vhit) begin
      fx = vx; fy = vy; d2 = dv2; side = SIDE_VERT;
    end else begin
      fx = 0; fy = 0; d2 = 0; side = SIDE_VERT; found = 0;
    end
    // fisheye correction
    if (found) begin
      len = int_sqrt(d2);
      cf = sine_q16(((view - ray) & (ANG_N - 1)) + ANG_Q);
      dist_q = cf > 0 ? (len * longint'(cf)) >> 16 : 0;
      if (dist_q > FAR_DIST) dist_q = FAR_DIST;
    end else begin
      dist_q = FAR_DIST;
    end
    res.found = found;
    res.x = fx[15:0];
    res.y = fy[15:0];
    res.distance = dist_q[15:0];
    res.side = side;
    return res;
  endfunction

  // track the map, queue predictions, compare result words
  always @(posedge clk) begin
    wall_hit_t want;
    if (rst) begin
      walls <= '0;
      hits_due.delete();
      fail_count <= 0;
      hit_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) walls <= cfg_data;
      if (start && !busy) hits_due.push_back(cast_ray(pos_x, pos_y, ray_angle, view_angle));
      if (done) begin
        if (hits_due.size() == 0) begin
          $error("result word with no ray outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = hits_due.pop_front();
          if (hit_found) hit_count <= hit_count + 1;
          if (hit_found !== want.found || hit_x !== want.x || hit_y !== want.y ||
              wall_distance !== want.distance || hit_side !== want.side)
            fail_count <= fail_count + 1;
          if (hit_found !== want.found)
            $error("hit_found expected %0d got %0d", want.found, hit_found);
          if (hit_x !== want.x) $error("hit_x expected %0d got %0d", want.x, hit_x);
          if (hit_y !== want.y) $error("hit_y expected %0d got %0d", want.y, hit_y);
          if (wall_distance !== want.distance)
            $error("wall_distance expected %0d got %0d", want.distance, wall_distance);
          if (hit_side !== want.side)
            $error("hit_side expected %0d got %0d", want.side, hit_side);
        end
      end
      pending <= hits_due.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives rays over a series of wall maps into the grid ray wall caster; a
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int POS_MAX     = 40959;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic [11:0] ray_angle = '0;
  logic [11:0] view_angle = '0;
  logic        cfg_write = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        done, hit_found, hit_side;
  logic [15:0] hit_x, hit_y, wall_distance;
  int          fail_count, pending, hit_count;
  int          cycles = 0;
  int          rays_sent = 0;
  int          maps_used = 0;

  always #5 clk = ~clk;

  grid_ray_wall_caster u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .ray_angle(ray_angle), .view_angle(view_angle),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .hit_found(hit_found), .hit_x(hit_x), .hit_y(hit_y),
    .wall_distance(wall_distance), .hit_side(hit_side)
  );

  gwc_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .ray_angle(ray_angle), .view_angle(view_angle),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .hit_found(hit_found), .hit_x(hit_x), .hit_y(hit_y),
    .wall_distance(wall_distance), .hit_side(hit_side),
    .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
  );

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_ray_wall_caster test failed");
      $finish;
    end
  end

  // present one ray word and hold it until taken
  task automatic cast(input logic [15:0] x, input logic [15:0] y,
                      input logic [11:0] ray, input logic [11:0] view);
    bit taken;
    start <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    ray_angle <= ray;
    view_angle <= view;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    rays_sent++;
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // load a new map once every outstanding ray has returned
  task automatic load_map(input logic [63:0] m);
    pause(1);
    wait (pending == 0);
    repeat (260) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    maps_used++;
  endtask

  function automatic logic [15:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'($urandom_range(0, 65535));
    if (r < 14) return 16'($urandom_range(0, 7) * 5120 + $urandom_range(0, 2) - 1);
    return 16'($urandom_range(0, POS_MAX));
  endfunction

  function automatic logic [11:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 12'($urandom_range(0, 7) * 512);
    if (r < 15) return 12'($urandom_range(0, 3) * 1024 + $urandom_range(0, 2) - 1);
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [63:0] pick_map(input int kind);
    logic [63:0] m;
    m = {$urandom(), $urandom()};
    case (kind % 4)
      0: m = m & {$urandom(), $urandom()} & {$urandom(), $urandom()};
      1: m = m & {$urandom(), $urandom()};
      2: m = m | {$urandom(), $urandom()};
      default: m = m;
    endcase
    return m;
  endfunction

  initial begin
    logic [11:0] ray;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty map then border ring and full map
    cast(16'd20000, 16'd20000, 12'd0, 12'd0);
    load_map(64'hFF81_8181_8181_81FF);
    cast(16'd0, 16'd0, 12'd3584, 12'd3584);
    cast(16'd20000, 16'd20000, 12'd0, 12'd0);
    cast(16'd20000, 16'd20000, 12'd1024, 12'd1024);
    cast(16'd20000, 16'd20000, 12'd2048, 12'd2048);
    cast(16'd20000, 16'd20000, 12'd3072, 12'd3072);
    cast(16'd20000, 16'd20000, 12'd512, 12'd4095);
    cast(16'd20000, 16'd20000, 12'd100, 12'd2148);
    cast(16'd20000, 16'd20000, 12'd300, 12'd1324);
    cast(16'd10240, 16'd15360, 12'd1536, 12'd1536);
    cast(16'd10239, 16'd15359, 12'd2560, 12'd2600);
    cast(16'd40959, 16'd40959, 12'd2560, 12'd2560);
    cast(16'd65535, 16'd65535, 12'd2560, 12'd4095);
    cast(16'd65535, 16'd0, 12'd4095, 12'd0);
    cast(16'd0, 16'd40959, 12'd1, 12'd1);
    load_map('1);
    cast(16'd5000, 16'd5000, 12'd3000, 12'd3000);
    cast(16'd40959, 16'd0, 12'd2047, 12'd2047);
    cast(16'd20480, 16'd20480, 12'd4095, 12'd0);

    // random bursts over a series of maps
    for (int phase = 0; phase < 6; phase++) begin
      load_map(phase == 5 ? 64'h0 : pick_map(phase));
      for (int i = 0; i < 215; i++) begin
        ray = pick_angle();
        cast(pick_pos(), pick_pos(), ray,
             $urandom_range(0, 3) == 0 ? pick_angle() : 12'(ray + $urandom_range(0, 700) - 350));
        if ($urandom_range(0, 5) == 0) pause($urandom_range(1, 300));
      end
    end
    load_map(64'h8000_0000_0000_0001);
    for (int i = 0; i < 20; i++) cast(pick_pos(), pick_pos(), pick_angle(), pick_angle());

    pause(1);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    $display("rays cast: %0d over %0d wall maps, %0d of them hit a wall",
             rays_sent, maps_used, hit_count);
    if (fail_count == 0) begin
      $display("grid_ray_wall_caster test passed");
    end else begin
      $display("grid_ray_wall_caster test failed");
    end
    $finish;
  end

endmodule
